@@ rtl/b64u_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_pkg
// Types, character codes and the alphabet map shared by the URL-safe
// base64 stream decoder.
// ----------------------------------------------------------------------------
package b64u_pkg;

    localparam logic [7:0] CHAR_DASH       = 8'h2D;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_PAD        = 8'h3D;
    localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0    = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9    = 8'h39;

    localparam logic [5:0] VAL_DASH       = 6'd62;
    localparam logic [5:0] VAL_UNDERSCORE = 6'd63;
    localparam logic [7:0] LOWER_OFFSET   = 8'd26;
    localparam logic [7:0] DIGIT_OFFSET   = 8'd52;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ENCODING = 2'd1,
        ST_PADDING  = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        status_t    status;
        logic       eom;
    } result_t;

    localparam result_t RESULT_NONE = '{data: 8'd0, has_byte: 1'b0, status: ST_OK, eom: 1'b0};

    // Bit 6 of the result flags a character outside the alphabet.
    function automatic logic [6:0] map_char(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            begin
                d = c - CHAR_UPPER_A;
            end
            else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            begin
                d = c - CHAR_LOWER_A + LOWER_OFFSET;
            end
            else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
            begin
                d = c - CHAR_DIGIT_0 + DIGIT_OFFSET;
            end
            else if (c == CHAR_DASH)
            begin
                d = {2'b00, VAL_DASH};
            end
            else if (c == CHAR_UNDERSCORE)
            begin
                d = {2'b00, VAL_UNDERSCORE};
            end
            else
            begin
                return 7'b1000000;
            end
            return {1'b0, d[5:0]};
        end
    endfunction

    function automatic result_t make_byte(input logic [7:0] data);
        result_t r;
        begin
            r          = RESULT_NONE;
            r.data     = data;
            r.has_byte = 1'b1;
            return r;
        end
    endfunction

endpackage

@@ rtl/base64url_stream_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64url_stream_decoder
// Decodes a stream of URL-safe base64 characters, with optional padding,
// into bytes and closes each message with one status result.
// ----------------------------------------------------------------------------
// The first result of a character is registered in the input register, then
// loaded into the result bundle once the bundle is free, and presented there.
// Throughput: one character per cycle unless in_stall; results leave at one per
// cycle unless out_stall, from a four-entry result bundle, so a character that
// yields several results holds the input until the bundle is at its last entry.
// Reset: asynchronous and active low; clears the group state and all valid flags.
module base64url_stream_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic [1:0] status,
    output logic       end_of_message
);
    import b64u_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  char_reg;
    logic        last_reg;

    logic [17:0] group_bits_reg;
    logic [17:0] group_bits_next;
    logic [1:0]  group_pos_reg;
    logic [1:0]  group_pos_next;
    logic [1:0]  pad_count_reg;
    logic [1:0]  pad_count_next;
    logic        bad_seen_reg;
    logic        bad_seen_next;

    result_t     pend_reg [4];
    result_t     pend_next [4];
    logic [2:0]  pend_cnt_reg;
    logic [2:0]  pend_cnt_next;

    result_t     items [4];
    logic [2:0]  n_items;
    logic [6:0]  mapped;
    logic        is_pad;
    logic        bad;
    logic        bad_any;
    logic [5:0]  six;
    logic [2:0]  count;
    logic [1:0]  pads;
    logic [1:0]  rem;
    logic [23:0] val;
    status_t     st;
    result_t     st_item;

    logic        out_take;
    logic        load;

    assign out_valid = (pend_cnt_reg != 3'd0);
    assign out_take  = out_valid && !out_stall;
    assign load      = in_valid_reg
                       && ((pend_cnt_reg == 3'd0) || ((pend_cnt_reg == 3'd1) && out_take));
    assign in_stall  = in_valid_reg && !load;

    assign out_byte       = pend_reg[0].data;
    assign has_byte       = pend_reg[0].has_byte;
    assign status         = pend_reg[0].status;
    assign end_of_message = pend_reg[0].eom;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            char_reg <= char_code;
            last_reg <= last_char;
        end
    end

    always_comb
    begin
        mapped  = map_char(char_reg);
        is_pad  = (char_reg == CHAR_PAD);
        bad     = mapped[6] && !is_pad;
        bad_any = bad_seen_reg || bad;
        six     = (is_pad || bad) ? 6'd0 : mapped[5:0];
        count   = {1'b0, group_pos_reg} + 3'd1;
        pads    = (is_pad && (pad_count_reg != 2'd3)) ? pad_count_reg + 2'd1 : pad_count_reg;
        rem     = count[1:0];
        val     = {group_bits_reg, six};
        st      = ST_OK;
        st_item = RESULT_NONE;
        n_items = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            items[i] = RESULT_NONE;
        end

        group_bits_next = {group_bits_reg[11:0], six};
        group_pos_next  = count[1:0];
        pad_count_next  = pads;
        bad_seen_next   = bad_any;

        if (count == 3'd4)
        begin
            if (!bad_any)
            begin
                items[n_items[1:0]] = make_byte(val[23:16]);
                n_items = n_items + 3'd1;
                if (pads < 2'd2)
                begin
                    items[n_items[1:0]] = make_byte(val[15:8]);
                    n_items = n_items + 3'd1;
                end
                if (pads < 2'd1)
                begin
                    items[n_items[1:0]] = make_byte(val[7:0]);
                    n_items = n_items + 3'd1;
                end
            end
            group_bits_next = 18'd0;
            group_pos_next  = 2'd0;
            pad_count_next  = 2'd0;
        end

        if (last_reg)
        begin
            if (is_pad && (rem != 2'd0))
            begin
                st = ST_PADDING;
            end
            else if (rem == 2'd1 || bad_any)
            begin
                st = ST_ENCODING;
            end

            if (st == ST_OK && rem == 2'd2)
            begin
                items[n_items[1:0]] = make_byte(group_bits_next[11:4]);
                n_items = n_items + 3'd1;
            end
            else if (st == ST_OK && rem == 2'd3)
            begin
                items[n_items[1:0]] = make_byte(group_bits_next[17:10]);
                n_items = n_items + 3'd1;
                items[n_items[1:0]] = make_byte(group_bits_next[9:2]);
                n_items = n_items + 3'd1;
            end

            st_item.status      = st;
            st_item.eom         = 1'b1;
            items[n_items[1:0]] = st_item;
            n_items             = n_items + 3'd1;

            group_bits_next = 18'd0;
            group_pos_next  = 2'd0;
            pad_count_next  = 2'd0;
            bad_seen_next   = 1'b0;
        end
    end

    always_comb
    begin
        pend_cnt_next = pend_cnt_reg;
        for (int i = 0; i < 4; i++)
        begin
            pend_next[i] = pend_reg[i];
        end
        if (load)
        begin
            pend_cnt_next = n_items;
            for (int i = 0; i < 4; i++)
            begin
                pend_next[i] = items[i];
            end
        end
        else if (out_take)
        begin
            pend_cnt_next = pend_cnt_reg - 3'd1;
            for (int i = 0; i < 3; i++)
            begin
                pend_next[i] = pend_reg[i + 1];
            end
            pend_next[3] = RESULT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_bits_reg <= 18'd0;
            group_pos_reg  <= 2'd0;
            pad_count_reg  <= 2'd0;
            bad_seen_reg   <= 1'b0;
            pend_cnt_reg   <= 3'd0;
        end
        else
        begin
            pend_cnt_reg <= pend_cnt_next;
            if (load)
            begin
                group_bits_reg <= group_bits_next;
                group_pos_reg  <= group_pos_next;
                pad_count_reg  <= pad_count_next;
                bad_seen_reg   <= bad_seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            pend_reg[i] <= pend_next[i];
        end
    end

    // A result carries data or closes the message, never both.
    a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (has_byte != end_of_message))
        else $error("result is neither a plain byte nor a closing status");

    a_bundle_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg <= 3'd4)
        else $error("result bundle count out of range");

    // The closing character of a message leaves the group state empty.
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (load && last_reg) |=> (group_pos_reg == 2'd0 && pad_count_reg == 2'd0
                                && !bad_seen_reg))
        else $error("group state not cleared at end of message");

    a_close_result: assert property (@(posedge clk) disable iff (!rst_n)
        (load && last_reg) |=> out_valid)
        else $error("closing character produced no status result");

endmodule

@@ bench/base64url_stream_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64url_stream_decoder_tb
// Self-checking bench for the URL-safe base64 stream decoder. Each accepted
// character is decoded by a behavioural predictor that queues the expected
// data bytes and closing status. Every output transfer is checked against
// the oldest entry, field by field. Directed messages cover the alphabet
// ends, padding forms, length and character errors. Random messages follow
// in phases with free flow, sender gaps, receiver stalls and both, one long
// receiver hold-off and one drain pause.
// ----------------------------------------------------------------------------
module base64url_stream_decoder_tb;

    import b64u_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_CHARS = 96;
    localparam int HOLD_CYCLES = 60;
    localparam int TAIL_CYCLES = 12;

    typedef enum logic [1:0] {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH
    } phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        status_t    st;
        logic       eom;
    } dec_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] char_code = 8'd0;
    logic       last_char = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       has_byte;
    logic [1:0] status;
    logic       end_of_message;

    char_item_t  char_q[$];
    dec_result_t expected_q[$];
    char_item_t  cur_item;
    dec_result_t want;

    phase_t      phase = PH_FREE;
    logic        in_taken = 1'b0;
    logic        hold_go = 1'b0;
    int          hold_left = 0;
    int          cycles = 0;
    int          errors = 0;
    int          queued_chars = 0;

    logic [17:0] grp_bits = '0;
    logic [1:0]  grp_pos = '0;
    logic [1:0]  grp_pads = '0;
    logic        msg_bad = 1'b0;

    base64url_stream_decoder uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_code      (char_code),
        .last_char      (last_char),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .has_byte       (has_byte),
        .status         (status),
        .end_of_message (end_of_message)
    );

    always #CLK_HALF clk = ~clk;

    function automatic int sextet_of(input logic [7:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            return int'(c - CHAR_UPPER_A);
        end
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
        begin
            return int'(c - CHAR_LOWER_A) + 26;
        end
        if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
        begin
            return int'(c - CHAR_DIGIT_0) + 52;
        end
        if (c == CHAR_DASH)
        begin
            return int'(VAL_DASH);
        end
        if (c == CHAR_UNDERSCORE)
        begin
            return int'(VAL_UNDERSCORE);
        end
        return -1;
    endfunction

    function automatic logic [7:0] alphabet_char(input int unsigned idx);
        if (idx < 26)
        begin
            return CHAR_UPPER_A + 8'(idx);
        end
        if (idx < 52)
        begin
            return CHAR_LOWER_A + 8'(idx - 26);
        end
        if (idx < 62)
        begin
            return CHAR_DIGIT_0 + 8'(idx - 52);
        end
        return (idx == 62) ? CHAR_DASH : CHAR_UNDERSCORE;
    endfunction

    function automatic void push_result(input logic [7:0] data, input logic has,
                                        input status_t st, input logic eom);
        dec_result_t r;
        r.data = data;
        r.has  = has;
        r.st   = st;
        r.eom  = eom;
        expected_q.push_back(r);
    endfunction

    task automatic decode_char(input logic [7:0] c, input logic last);
        int          v;
        logic        is_pad;
        logic        bad;
        logic [5:0]  six;
        logic [2:0]  count;
        logic [2:0]  pads;
        logic [1:0]  rem;
        logic [23:0] word;
        status_t     st;
        v      = sextet_of(c);
        is_pad = (c == CHAR_PAD);
        bad    = !is_pad && (v < 0);
        six    = (is_pad || bad) ? 6'd0 : v[5:0];
        count  = {1'b0, grp_pos} + 3'd1;
        pads   = {1'b0, grp_pads} + {2'b00, is_pad};
        if (pads > 3'd3)
        begin
            pads = 3'd3;
        end
        if (bad)
        begin
            msg_bad = 1'b1;
        end
        if (count == 3'd4)
        begin
            word = {grp_bits, six};
            if (!msg_bad)
            begin
                push_result(word[23:16], 1'b1, ST_OK, 1'b0);
                if (pads < 3'd2)
                begin
                    push_result(word[15:8], 1'b1, ST_OK, 1'b0);
                end
                if (pads < 3'd1)
                begin
                    push_result(word[7:0], 1'b1, ST_OK, 1'b0);
                end
            end
            grp_bits = '0;
            grp_pos  = '0;
            grp_pads = '0;
        end
        else
        begin
            grp_bits = {grp_bits[11:0], six};
            grp_pos  = count[1:0];
            grp_pads = pads[1:0];
        end
        if (last)
        begin
            rem = count[1:0];
            if (is_pad && rem != 2'd0)
            begin
                st = ST_PADDING;
            end
            else if (rem == 2'd1 || msg_bad)
            begin
                st = ST_ENCODING;
            end
            else
            begin
                st = ST_OK;
            end
            if (st == ST_OK && rem == 2'd2)
            begin
                push_result(grp_bits[11:4], 1'b1, ST_OK, 1'b0);
            end
            else if (st == ST_OK && rem == 2'd3)
            begin
                push_result(grp_bits[17:10], 1'b1, ST_OK, 1'b0);
                push_result(grp_bits[9:2], 1'b1, ST_OK, 1'b0);
            end
            push_result(8'd0, 1'b0, st, 1'b1);
            grp_bits = '0;
            grp_pos  = '0;
            grp_pads = '0;
            msg_bad  = 1'b0;
        end
    endtask

    task automatic push_char(input logic [7:0] c, input logic last);
        char_item_t it;
        it.ch   = c;
        it.last = last;
        char_q.push_back(it);
        queued_chars++;
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            push_char(s[i], i == s.len() - 1);
        end
    endtask

    task automatic add_random_message();
        int unsigned kind;
        int unsigned len;
        int unsigned rnd;
        int          i;
        logic [7:0]  chars[$];
        kind = $urandom_range(0, 99);
        len  = $urandom_range(1, 14);
        if (kind < 70)
        begin
            if (len % 4 == 1)
            begin
                len++;
            end
            for (i = 0; i < len; i++)
            begin
                chars.push_back(alphabet_char($urandom_range(0, 63)));
            end
            if (len % 4 != 0 && $urandom_range(0, 1) == 1)
            begin
                while (chars.size() % 4 != 0)
                begin
                    chars.push_back(CHAR_PAD);
                end
            end
        end
        else if (kind < 85)
        begin
            for (i = 0; i < len; i++)
            begin
                rnd = $urandom_range(0, 255);
                case ($urandom_range(0, 3))
                    0: chars.push_back(rnd[7:0]);
                    1: chars.push_back(CHAR_PAD);
                    default: chars.push_back(alphabet_char($urandom_range(0, 63)));
                endcase
            end
        end
        else
        begin
            for (i = 0; i < len; i++)
            begin
                chars.push_back(alphabet_char($urandom_range(0, 63)));
            end
            if ($urandom_range(0, 1) == 1)
            begin
                chars[$urandom_range(0, len - 1)] = CHAR_PAD;
            end
            else
            begin
                chars.push_back(CHAR_PAD);
            end
        end
        for (i = 0; i < chars.size(); i++)
        begin
            push_char(chars[i], i == chars.size() - 1);
        end
    endtask

    task automatic add_random_phase();
        int start;
        start = queued_chars;
        while (queued_chars - start < PHASE_CHARS)
        begin
            add_random_message();
        end
    endtask

    task automatic wait_until_idle();
        while (!(char_q.size() == 0 && !in_valid && expected_q.size() == 0))
        begin
            @(posedge clk);
            #1;
        end
    endtask

    // Input driver: a pending transfer is held until accepted.
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (char_q.size() != 0 &&
                $urandom_range(0, 99) >= ((phase == PH_SEND_IDLE) ? 58 :
                                          (phase == PH_BOTH) ? 35 : 0))
            begin
                cur_item = char_q.pop_front();
                char_code <= cur_item.ch;
                last_char <= cur_item.last;
                in_valid  <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= (hold_left != 0) ||
                     ($urandom_range(0, 99) < ((phase == PH_RECV_STALL) ? 58 :
                                               (phase == PH_BOTH) ? 35 : 0));
    end

    always @(posedge clk)
    begin
        if (hold_go)
        begin
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: predicts on each input transfer and checks each output transfer.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                decode_char(char_code, last_char);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result: out_byte %02h has_byte %0d status %0d eom %0d",
                           out_byte, has_byte, status, end_of_message);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %02h, actual %02h", want.data, out_byte);
                        errors++;
                    end
                    if (has_byte !== want.has)
                    begin
                        $error("has_byte: expected %0d, actual %0d", want.has, has_byte);
                        errors++;
                    end
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, actual %0d", want.st, status);
                        errors++;
                    end
                    if (end_of_message !== want.eom)
                    begin
                        $error("end_of_message: expected %0d, actual %0d",
                               want.eom, end_of_message);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        #1;
        rst_n = 1'b1;

        phase = PH_FREE;
        push_text("_-9z");
        push_text("QQ==");
        push_text("QUE=");
        push_text("Q=A");
        push_text("A");
        push_text("QQ=");
        push_char(8'h00, 1'b0);
        push_text("QQ");
        push_text("Zm9v");
        char_q[char_q.size() - 1].last = 1'b0;
        push_char(8'hFF, 1'b0);
        push_char(CHAR_PAD, 1'b1);
        add_random_phase();

        // Long receiver hold-off while characters keep coming.
        while (char_q.size() > 60)
        begin
            @(posedge clk);
            #1;
        end
        hold_go = 1'b1;
        @(posedge clk);
        #1;
        hold_go = 1'b0;

        while (char_q.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
        phase = PH_SEND_IDLE;
        add_random_phase();

        wait_until_idle();
        phase = PH_RECV_STALL;
        add_random_phase();

        while (char_q.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
        phase = PH_BOTH;
        add_random_phase();

        wait_until_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
